FILE: hdl/otrip_pkg.sv
// Shared types, constants and register codes for the three-phase overcurrent trip.
// Used by the configuration, controller, datapath and top-level modules.
// No dependencies.
package otrip_pkg;

   localparam int ADC_BITS = 10;
   localparam int SAMPLE_W = 10;
   localparam int QUOT_W = 14;
   localparam int REM_W = 10;
   localparam int THR_W = 20;
   localparam int GAIN_W = 4;
   localparam int GAIN50_W = 10;
   localparam int PROD_W = SAMPLE_W + GAIN50_W;
   localparam int TENTHS_W = PROD_W - ADC_BITS;
   localparam int COUNT_W = 8;
   localparam int STEP_W = 4;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W = 10;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 32;

   localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(QUOT_W - 1);
   localparam logic [STEP_W-1:0] PHASE_LAST = STEP_W'(2);
   localparam logic [GAIN50_W-1:0] GAIN_SCALE = GAIN50_W'(50);
   localparam logic [QUOT_W-1:0] SET_SCALE = QUOT_W'(10);
   localparam logic [THR_W-1:0] MIN_SCALE = THR_W'(10);
   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   localparam logic [1:0] FIRST_NONE = 2'd0;

   localparam logic [CSR_INDEX_W-1:0] REG_SET_MIN = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_SET_SPAN = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_ADC_FULL = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_GAIN = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_REL_TICKS = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_REL_RELOAD = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_BLINK_PERIOD = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_BLINK_ON = 3'd7;

   typedef struct packed {
      logic [5:0] set_min_amps;
      logic [5:0] set_span_amps;
      logic [9:0] set_adc_full;
      logic [GAIN_W-1:0] current_gain;
      logic [COUNT_W-1:0] release_ticks;
      logic [COUNT_W-1:0] release_reload;
      logic [COUNT_W-1:0] blink_period;
      logic [COUNT_W-1:0] blink_on_ticks;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      set_min_amps: 6'd8,
      set_span_amps: 6'd12,
      set_adc_full: 10'd840,
      current_gain: 4'd6,
      release_ticks: 8'd10,
      release_reload: 8'd6,
      blink_period: 8'd10,
      blink_on_ticks: 8'd5
   };

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_THR,
      ST_PHASE,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic load;
      logic div_step;
      logic thr_load;
      logic phase_check;
      logic [1:0] phase_sel;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic out_blocked;
   } status_type;

endpackage

FILE: hdl/otrip_csr.sv
// Configuration register file of the overcurrent trip.
// Depends on otrip_pkg for the register codes, reset values and cfg_type.
module otrip_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [otrip_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [otrip_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output otrip_pkg::cfg_type                    cfg
);

   otrip_pkg::cfg_type cfg_ff;
   otrip_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            otrip_pkg::REG_SET_MIN: cfg_in.set_min_amps = csr_wdata[5:0];
            otrip_pkg::REG_SET_SPAN: cfg_in.set_span_amps = csr_wdata[5:0];
            otrip_pkg::REG_ADC_FULL: cfg_in.set_adc_full = csr_wdata[9:0];
            otrip_pkg::REG_GAIN: cfg_in.current_gain = csr_wdata[3:0];
            otrip_pkg::REG_REL_TICKS: cfg_in.release_ticks = csr_wdata[7:0];
            otrip_pkg::REG_REL_RELOAD: cfg_in.release_reload = csr_wdata[7:0];
            otrip_pkg::REG_BLINK_PERIOD: cfg_in.blink_period = csr_wdata[7:0];
            otrip_pkg::REG_BLINK_ON: cfg_in.blink_on_ticks = csr_wdata[7:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= otrip_pkg::CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

FILE: hdl/otrip_ctrl.sv
// Sequencing state machine of the overcurrent trip.
// Depends on otrip_pkg for state_type, cmd_type and status_type.
module otrip_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  otrip_pkg::status_type    status,
   output otrip_pkg::cmd_type       cmd
);

   otrip_pkg::state_type state_ff;
   otrip_pkg::state_type state_in;
   logic [otrip_pkg::STEP_W-1:0] step_ff;
   logic [otrip_pkg::STEP_W-1:0] step_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= otrip_pkg::ST_IDLE;
         step_ff <= '0;
      end else begin
         state_ff <= state_in;
         step_ff <= step_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      step_in = step_ff;
      cmd = '0;
      req_tready = 1'b0;
      case (state_ff)
         otrip_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               step_in = '0;
               state_in = otrip_pkg::ST_DIV;
            end
         end
         otrip_pkg::ST_DIV: begin
            cmd.div_step = 1'b1;
            if (step_ff == otrip_pkg::DIV_LAST) begin
               step_in = '0;
               state_in = otrip_pkg::ST_THR;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         otrip_pkg::ST_THR: begin
            cmd.thr_load = 1'b1;
            step_in = '0;
            state_in = otrip_pkg::ST_PHASE;
         end
         otrip_pkg::ST_PHASE: begin
            cmd.phase_check = 1'b1;
            cmd.phase_sel = step_ff[1:0] + 2'd1;
            if (step_ff == otrip_pkg::PHASE_LAST) begin
               step_in = '0;
               state_in = otrip_pkg::ST_FINISH;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         otrip_pkg::ST_FINISH: begin
            if (!status.out_blocked) begin
               cmd.finish = 1'b1;
               state_in = otrip_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = otrip_pkg::ST_IDLE;
            step_in = '0;
         end
      endcase
   end

   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.div_step, cmd.thr_load, cmd.phase_check, cmd.finish}))
      else $error("more than one datapath command at once");

   a_finish_not_blocked: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> !status.out_blocked)
      else $error("result written while previous result still stalled");

endmodule

FILE: hdl/otrip_dp.sv
// Datapath of the overcurrent trip: setpoint divider, threshold and phase scaling,
// trip state and result register. Depends on otrip_pkg for types and constants.
module otrip_dp (
   input  logic                                  clock,
   input  logic                                  reset,
   input  otrip_pkg::cfg_type                    cfg,
   input  otrip_pkg::cmd_type                    cmd,
   output otrip_pkg::status_type                 status,
   input  logic [otrip_pkg::REQ_DATA_W-1:0]      req_tdata,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [otrip_pkg::RSP_DATA_W-1:0]      rsp_tdata
);

   logic [otrip_pkg::SAMPLE_W-1:0] phase1_ff, phase2_ff, phase3_ff;
   logic [otrip_pkg::QUOT_W-1:0] dq_ff;
   logic [otrip_pkg::QUOT_W-1:0] dq_in;
   logic [otrip_pkg::REM_W-1:0] rem_ff;
   logic [otrip_pkg::REM_W-1:0] rem_in;
   logic [otrip_pkg::THR_W-1:0] thr_ff;
   logic [1:0] first_ff;
   logic warn_ff;
   logic [otrip_pkg::COUNT_W-1:0] release_ff;
   logic [otrip_pkg::COUNT_W-1:0] blink_ff;
   logic rsp_valid_ff;
   logic rsp_relay_ff, rsp_buzzer_ff, rsp_warn_ff;
   logic [1:0] rsp_first_ff;
   logic [otrip_pkg::THR_W-1:0] rsp_thr_ff;

   logic [otrip_pkg::REM_W-1:0] full_eff;
   logic [otrip_pkg::REM_W:0] trial;
   logic trial_ge;
   logic [otrip_pkg::SAMPLE_W-1:0] phase_sample;
   logic [otrip_pkg::GAIN50_W-1:0] gain50;
   logic [otrip_pkg::PROD_W-1:0] phase_prod;
   logic [otrip_pkg::TENTHS_W-1:0] phase_tenths;
   logic phase_over;
   logic [otrip_pkg::COUNT_W-1:0] blink_inc, blink_next;
   logic [otrip_pkg::COUNT_W-1:0] release_inc;
   logic warn_next;
   logic [otrip_pkg::COUNT_W-1:0] release_next;

   assign status.out_blocked = rsp_valid_ff && !rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {7'd0, rsp_thr_ff, rsp_first_ff, rsp_warn_ff, rsp_buzzer_ff,
                       rsp_relay_ff};

   // Restoring division of setpoint*10 by the full-scale reading, one bit a cycle.
   assign full_eff = (cfg.set_adc_full == '0) ? otrip_pkg::REM_W'(1) : cfg.set_adc_full;
   assign trial = {rem_ff, dq_ff[otrip_pkg::QUOT_W-1]};
   assign trial_ge = trial >= {1'b0, full_eff};

   always_comb begin
      dq_in = dq_ff;
      rem_in = rem_ff;
      if (cmd.load) begin
         dq_in = otrip_pkg::QUOT_W'(req_tdata[9:0]) * otrip_pkg::SET_SCALE;
         rem_in = '0;
      end else if (cmd.div_step) begin
         dq_in = {dq_ff[otrip_pkg::QUOT_W-2:0], trial_ge};
         rem_in = trial_ge ? otrip_pkg::REM_W'(trial - {1'b0, full_eff})
                           : trial[otrip_pkg::REM_W-1:0];
      end
   end

   assign gain50 = otrip_pkg::GAIN50_W'(cfg.current_gain) * otrip_pkg::GAIN_SCALE;

   always_comb begin
      case (cmd.phase_sel)
         2'd1: phase_sample = phase1_ff;
         2'd2: phase_sample = phase2_ff;
         2'd3: phase_sample = phase3_ff;
         default: phase_sample = phase1_ff;
      endcase
   end

   assign phase_prod = otrip_pkg::PROD_W'(phase_sample) * otrip_pkg::PROD_W'(gain50);
   assign phase_tenths = phase_prod[otrip_pkg::PROD_W-1:otrip_pkg::ADC_BITS];
   assign phase_over = otrip_pkg::THR_W'(phase_tenths) > thr_ff;

   assign blink_inc = blink_ff + 1'b1;
   assign blink_next = (blink_inc >= cfg.blink_period) ? '0 : blink_inc;
   assign release_inc = (release_ff == otrip_pkg::COUNT_MAX) ? release_ff
                                                            : release_ff + 1'b1;

   always_comb begin
      warn_next = warn_ff;
      release_next = release_inc;
      if (first_ff != otrip_pkg::FIRST_NONE) begin
         warn_next = 1'b1;
         release_next = '0;
      end else if (release_inc > cfg.release_ticks) begin
         warn_next = 1'b0;
         release_next = cfg.release_reload;
      end
   end

   always_ff @(posedge clock) begin
      dq_ff <= dq_in;
      rem_ff <= rem_in;
      if (cmd.load) begin
         phase1_ff <= req_tdata[19:10];
         phase2_ff <= req_tdata[29:20];
         phase3_ff <= req_tdata[39:30];
      end
      if (cmd.thr_load) begin
         thr_ff <= otrip_pkg::THR_W'(dq_ff) * otrip_pkg::THR_W'(cfg.set_span_amps)
                   + otrip_pkg::THR_W'(cfg.set_min_amps) * otrip_pkg::MIN_SCALE;
      end
      if (cmd.finish) begin
         rsp_relay_ff <= warn_ff;
         rsp_buzzer_ff <= warn_ff && (blink_next < cfg.blink_on_ticks);
         rsp_warn_ff <= warn_next;
         rsp_first_ff <= first_ff;
         rsp_thr_ff <= thr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff <= otrip_pkg::FIRST_NONE;
         warn_ff <= 1'b0;
         release_ff <= '0;
         blink_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.load) begin
            first_ff <= otrip_pkg::FIRST_NONE;
         end else if (cmd.phase_check && phase_over && first_ff == otrip_pkg::FIRST_NONE) begin
            first_ff <= cmd.phase_sel;
         end
         if (cmd.finish) begin
            warn_ff <= warn_next;
            release_ff <= release_next;
            blink_ff <= blink_next;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   a_finish_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_valid_ff)
      else $error("result register not loaded after finish");

   a_trip_sets_warning: assert property (@(posedge clock) disable iff (reset)
      cmd.finish && first_ff != otrip_pkg::FIRST_NONE |=> rsp_warn_ff && warn_ff)
      else $error("phase over threshold did not set the warning");

endmodule

FILE: hdl/three_phase_overcurrent_trip.sv
// Top level of the three-phase overcurrent trip: configuration registers,
// controller and datapath. Depends on otrip_pkg, otrip_csr, otrip_ctrl and otrip_dp.
//
//   Channel   Direction  Handshake              Payload
//   req_      in         req_tvalid/req_tready  setpoint and three phase samples
//   rsp_      out        rsp_tvalid/rsp_tready  drives, warning, first phase, threshold
//   csr_      in         csr_valid/csr_ready    register index and write data
//
// An item passes through these steps in order: accept, the bit-serial setpoint divider,
// forming the threshold, a step for each phase on the shared scaling multiplier,
// then updating the trip state and loading the result register.
// A new item is accepted while the previous result waits to be taken; a stalled
// result holds the controller only at the final update step.
// Synchronous reset restores the register defaults and clears warning and counters.
module three_phase_overcurrent_trip (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // setpoint_sample[9:0], phase1_sample[19:10], phase2_sample[29:20],
   // phase3_sample[39:30]
   input  logic [otrip_pkg::REQ_DATA_W-1:0]      req_tdata,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // relay_drive[0], buzzer_drive[1], warning_now[2], first_phase_over[4:3],
   // threshold_tenths[24:5], zeros above
   output logic [otrip_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [otrip_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [otrip_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   otrip_pkg::cfg_type cfg;
   otrip_pkg::cmd_type cmd;
   otrip_pkg::status_type status;

   otrip_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   otrip_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   otrip_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
